// ===== rtl/core/hsv_to_rgb_converter_macros.svh =====
// Assertion helpers used by the color converter top level.
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// Check that a condition implies a consequent (which may carry a delay).
`define HSV_ASSERT_IMPL(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> cons) \
        else $error("hsv_to_rgb_converter: implication check failed");

// Check that a condition never holds.
`define HSV_ASSERT_NEVER(label, clock, resetn, cond) \
    label: assert property (@(posedge clock) disable iff (!resetn) !(cond)) \
        else $error("hsv_to_rgb_converter: forbidden condition seen");

`endif

// ===== rtl/core/hsv_pkg.sv =====
`default_nettype none

package hsv_pkg;

    // One input item: hue in degrees, saturation and value in percent
    typedef struct packed {
        logic [8:0] hue;
        logic [6:0] saturation;
        logic [6:0] brightness;
    } hsv_in_t;

    // One result item
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } hsv_out_t;

    // Per-channel weight k: channel numerator is V*6000 - S*V*k
    typedef struct packed {
        logic [5:0] red;
        logic [5:0] green;
        logic [5:0] blue;
    } hsv_k_t;

    // Per-channel numerator over the common denominator 600000
    typedef struct packed {
        logic signed [20:0] red;
        logic signed [20:0] green;
        logic signed [20:0] blue;
    } hsv_num_t;

    // Hue sector bounds
    localparam logic [8:0] HUE_60  = 9'd60;
    localparam logic [8:0] HUE_120 = 9'd120;
    localparam logic [8:0] HUE_180 = 9'd180;
    localparam logic [8:0] HUE_240 = 9'd240;
    localparam logic [8:0] HUE_300 = 9'd300;
    localparam logic [8:0] HUE_360 = 9'd360;
    localparam logic [8:0] HUE_480 = 9'd480;

    // Weights: chroma term, ramp term is the gap from the ramp peak, zero term
    localparam logic [5:0] K_CHROMA = 6'd0;
    localparam logic [5:0] K_ZERO   = 6'd60;

    // Value scale: V*6000 is the value fraction over 600000
    localparam logic [19:0] V_SCALE = 20'd6000;

    // num*255/600000 == num*17/40000
    localparam logic [23:0] DIV_DEN   = 24'd40000;
    localparam logic [16:0] DIV_RECIP = 17'd107374;  // floor(2^32 / 40000)
    localparam int          DIV_SHIFT = 32;
    // Smallest numerator whose channel would exceed 255
    localparam logic signed [20:0] NUM_SAT = 21'sd602353;

    localparam logic [7:0] CHAN_MAX = 8'd255;

    // Place chroma, ramp and zero on the channels by hue sector
    function automatic hsv_k_t hsv_weights(input logic [8:0] hue, input logic [5:0] ramp_gap);
        hsv_k_t k;
        if (hue < HUE_60) begin
            k = '{red: K_CHROMA, green: ramp_gap, blue: K_ZERO};
        end else if (hue < HUE_120) begin
            k = '{red: ramp_gap, green: K_CHROMA, blue: K_ZERO};
        end else if (hue < HUE_180) begin
            k = '{red: K_ZERO, green: K_CHROMA, blue: ramp_gap};
        end else if (hue < HUE_240) begin
            k = '{red: K_ZERO, green: ramp_gap, blue: K_CHROMA};
        end else if (hue < HUE_300) begin
            k = '{red: ramp_gap, green: K_ZERO, blue: K_CHROMA};
        end else begin
            k = '{red: K_CHROMA, green: K_ZERO, blue: ramp_gap};
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hsv_front.sv =====
`default_nettype none

module hsv_front
    import hsv_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire hsv_in_t  in_item,
    output logic          out_valid,
    output hsv_num_t      out_num
);

    logic [8:0]  hue_base;
    logic [6:0]  hue_mod;
    logic [5:0]  ramp_gap;

    logic        valid1_reg;
    logic [13:0] sv_reg;
    logic [13:0] sv_next;
    logic [19:0] vscaled_reg;
    logic [19:0] vscaled_next;
    hsv_k_t      k_reg;
    hsv_k_t      k_next;

    logic        valid2_reg;
    hsv_num_t    num_reg;
    hsv_num_t    num_next;

    // Fold hue into 0..119 and take the distance from the ramp peak
    always_comb
    begin
        if (in_item.hue >= HUE_480) begin
            hue_base = HUE_480;
        end else if (in_item.hue >= HUE_360) begin
            hue_base = HUE_360;
        end else if (in_item.hue >= HUE_240) begin
            hue_base = HUE_240;
        end else if (in_item.hue >= HUE_120) begin
            hue_base = HUE_120;
        end else begin
            hue_base = '0;
        end
        hue_mod = 7'(in_item.hue - hue_base);
        if (hue_mod >= 7'(HUE_60)) begin
            ramp_gap = 6'(hue_mod - 7'(HUE_60));
        end else begin
            ramp_gap = 6'(7'(HUE_60) - hue_mod);
        end
        k_next       = hsv_weights(in_item.hue, ramp_gap);
        sv_next      = 14'(in_item.saturation) * 14'(in_item.brightness);
        vscaled_next = 20'(in_item.brightness) * V_SCALE;
    end

    // Form each channel numerator V*6000 - S*V*k
    always_comb
    begin
        num_next.red   = 21'({1'b0, vscaled_reg}) - 21'(20'(sv_reg) * 20'(k_reg.red));
        num_next.green = 21'({1'b0, vscaled_reg}) - 21'(20'(sv_reg) * 20'(k_reg.green));
        num_next.blue  = 21'({1'b0, vscaled_reg}) - 21'(20'(sv_reg) * 20'(k_reg.blue));
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end else begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        sv_reg      <= sv_next;
        vscaled_reg <= vscaled_next;
        k_reg       <= k_next;
        num_reg     <= num_next;
    end

    assign out_valid = valid2_reg;
    assign out_num   = num_reg;

endmodule

`default_nettype wire

// ===== rtl/core/hsv_scale.sv =====
`default_nettype none

module hsv_scale
    import hsv_pkg::*;
(
    input  wire logic               clk,
    input  wire logic signed [20:0] num,
    output logic             [7:0]  chan
);

    logic        zero_next;
    logic        sat_next;
    logic [23:0] n17_next;
    logic        zero3_reg;
    logic        sat3_reg;
    logic [23:0] n17_3_reg;

    logic [40:0] prod;
    logic [8:0]  q0_next;
    logic        zero4_reg;
    logic        sat4_reg;
    logic [23:0] n17_4_reg;
    logic [8:0]  q0_reg;

    logic [24:0] rem;
    logic [8:0]  quot;
    logic [7:0]  chan_next;
    logic [7:0]  chan_reg;

    // Flag the clamp cases and scale the magnitude by 17
    always_comb
    begin
        zero_next = num[20] || (num == '0);
        sat_next  = (num >= NUM_SAT);
        n17_next  = {num[19:0], 4'b0000} + {4'b0000, num[19:0]};
    end

    // Estimate the quotient by reciprocal; it is exact or one short
    always_comb
    begin
        prod    = 41'(n17_3_reg) * 41'(DIV_RECIP);
        q0_next = prod[DIV_SHIFT +: 9];
    end

    // Correct the estimate and apply the clamps
    always_comb
    begin
        rem  = {1'b0, n17_4_reg} - 25'(24'(q0_reg) * DIV_DEN);
        quot = q0_reg + 9'(rem >= {1'b0, DIV_DEN});
        if (zero4_reg) begin
            chan_next = '0;
        end else if (sat4_reg) begin
            chan_next = CHAN_MAX;
        end else begin
            chan_next = quot[7:0];
        end
    end

    // Advance payload through the three stages
    always_ff @(posedge clk)
    begin
        zero3_reg <= zero_next;
        sat3_reg  <= sat_next;
        n17_3_reg <= n17_next;
        zero4_reg <= zero3_reg;
        sat4_reg  <= sat3_reg;
        n17_4_reg <= n17_3_reg;
        q0_reg    <= q0_next;
        chan_reg  <= chan_next;
    end

    assign chan = chan_reg;

endmodule

`default_nettype wire

// ===== rtl/core/hsv_to_rgb_converter.sv =====
// Channel   Direction  Handshake          Payload
// command   in         start / busy       item   (hsv_in_t: hue, saturation, brightness)
// result    out        done (one cycle)   result (hsv_out_t: red, green, blue)
//
// One item is taken every cycle; busy is never raised.
// Each result is formed in a pipeline: two stages form the channel
// numerators (sector weights, S*V product, then V*6000 - S*V*k), three stages
// scale by 255/600000 (clamp flags, reciprocal multiply, correction).
// Reset clears only the valid bits; no state outlives an item.
// The receiver cannot stall, so done is a single-cycle strobe per item.
`default_nettype none
`include "hsv_to_rgb_converter_macros.svh"

module hsv_to_rgb_converter
    import hsv_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire hsv_in_t item,
    output logic         done,
    output hsv_out_t     result
);

    logic     front_valid;
    hsv_num_t front_num;
    logic [2:0] vpipe_reg;
    logic [2:0] vpipe_next;

    // Numerator stages
    hsv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .in_item   (item),
        .out_valid (front_valid),
        .out_num   (front_num)
    );

    // Scaling stages, one per channel
    hsv_scale u_scale_red (
        .clk  (clk),
        .num  (front_num.red),
        .chan (result.red)
    );

    hsv_scale u_scale_green (
        .clk  (clk),
        .num  (front_num.green),
        .chan (result.green)
    );

    hsv_scale u_scale_blue (
        .clk  (clk),
        .num  (front_num.blue),
        .chan (result.blue)
    );

    // Carry valid alongside the scaling stages
    assign vpipe_next = {vpipe_reg[1:0], front_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vpipe_reg <= '0;
        end else begin
            vpipe_reg <= vpipe_next;
        end
    end

    assign done = vpipe_reg[2];
    assign busy = 1'b0;

    // Every item yields one result, and nothing else does
    `HSV_ASSERT_IMPL(a_result_follows, clk, rst_n, start, ##5 done)
    `HSV_ASSERT_IMPL(a_no_spurious, clk, rst_n, !start, ##5 !done)
    // Zero brightness gives black
    `HSV_ASSERT_NEVER(a_dark_is_black, clk, rst_n, done && ($past(item.brightness, 5) == '0) && (result != '0))

endmodule

`default_nettype wire
